[hdl/sorted_table_floor_search_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table floor search block.
// Both macros expect clk and rst_n in scope and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_FLOOR_SEARCH_MACROS_SVH
`define SORTED_TABLE_FLOOR_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stfs_pkg.sv]
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared widths, codes and memory request types of the floor search block.
// ----------------------------------------------------------------------------
package stfs_pkg;

  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;
  localparam int DATA_W  = 32;
  localparam int DEPTH   = 1 << IDX_W;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_BELOW = 2'd1,
    ST_SMALL = 2'd2
  } status_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

endpackage

[hdl/stfs_table.sv]
// ----------------------------------------------------------------------------
// stfs_table
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stfs_table import stfs_pkg::*; (
  input  logic                     clk,
  input  mem_wr_t                  wr,
  input  mem_rd_t                  rd,
  output logic signed [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = $signed(rd_data_r);

endmodule

[hdl/sorted_table_floor_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_floor_search
// A query reads entry 0 at its accept, checks it in S_FIRST and then bisects in
// S_PROBE with one table read per step until one entry is left; a key below
// entry 0 answers from S_FIRST and a count below two answers from idle.
// Busy stays high while a query searches, so a new item waits for the last
// result; a load gives no result.
// Synchronous active-low reset clears the count and the sequencer, not the table.
// ----------------------------------------------------------------------------
module sorted_table_floor_search import stfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_func,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_value,
  input  logic signed [DATA_W-1:0] in_search_key,
  // Result channel, one cycle per result, no back-pressure
  output logic                     out_strobe,
  output logic [IDX_W-1:0]         out_result_index,
  output logic [1:0]               out_status,
  // Count register
  input  logic                     cfg_we,
  input  logic [COUNT_W-1:0]       cfg_wdata
);

  `include "sorted_table_floor_search_macros.svh"

  // S_FIRST checks entry 0; S_PROBE runs one bisection step per cycle.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_PROBE
  } state_t;

  state_t                     state_r;
  logic [COUNT_W-1:0]         table_count_r;
  logic                       out_strobe_r;
  logic [IDX_W-1:0]           out_result_index_r;
  status_t                    out_status_r;

  // Bisection window: entry[lo] <= key holds, hi is an exclusive bound.
  logic [IDX_W-1:0]           lo_r;
  logic [COUNT_W-1:0]         hi_r;
  logic [IDX_W-1:0]           mid_r;
  logic signed [DATA_W-1:0]   key_r;

  logic                       accept;
  logic [COUNT_W-1:0]         count_sat;
  logic signed [DATA_W-1:0]   rd_data;
  logic                       entry_le_key;
  logic [IDX_W-1:0]           lo_nxt;
  logic [COUNT_W-1:0]         hi_nxt;
  logic [COUNT_W-1:0]         span;
  logic                       more;
  logic [COUNT_W-1:0]         mid_nxt;
  mem_wr_t                    mem_wr;
  mem_rd_t                    mem_rd;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // A count above the table depth searches the whole table.
  assign count_sat = (table_count_r > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : table_count_r;

  // The one shared compare: the entry just read against the key.
  assign entry_le_key = (rd_data <= key_r);

  // Next window and midpoint. In S_FIRST entry 0 is checked and the window
  // stays [0, n), so the first midpoint is taken from it.
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (state_r == S_PROBE) begin
      if (entry_le_key) begin
        lo_nxt = mid_r;
      end else begin
        hi_nxt = {1'b0, mid_r};
      end
    end
    span    = hi_nxt - {1'b0, lo_nxt};
    more    = (span > COUNT_W'(1));
    mid_nxt = {1'b0, lo_nxt} + (span >> 1);
  end

  // Table ports. A load writes in its accept cycle; a query reads entry 0 at
  // its accept and then the next midpoint every cycle while it searches.
  always_comb begin
    mem_wr.en   = accept && (in_func == FUNC_WRITE) &&
                  ({1'b0, in_entry_index} < COUNT_W'(DEPTH));
    mem_wr.addr = in_entry_index;
    mem_wr.data = in_entry_value;

    mem_rd.en   = 1'b0;
    mem_rd.addr = mid_nxt[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_rd.en   = accept && (in_func == FUNC_QUERY);
        mem_rd.addr = '0;
      end
      S_FIRST: mem_rd.en = 1'b1;
      S_PROBE: mem_rd.en = more;
      default: mem_rd.en = 1'b0;
    endcase
  end

  stfs_table u_table (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  // Sequencer, count register and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      table_count_r      <= '0;
      out_strobe_r       <= 1'b0;
      out_result_index_r <= '0;
      out_status_r       <= ST_FOUND;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        table_count_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_func == FUNC_QUERY)) begin
            if (count_sat < COUNT_W'(2)) begin
              out_strobe_r       <= 1'b1;
              out_result_index_r <= '0;
              out_status_r       <= ST_SMALL;
            end else begin
              state_r <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (!entry_le_key) begin
            // The key lies below every entry.
            out_strobe_r       <= 1'b1;
            out_result_index_r <= '0;
            out_status_r       <= ST_BELOW;
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!more) begin
            out_strobe_r       <= 1'b1;
            out_result_index_r <= lo_nxt;
            out_status_r       <= ST_FOUND;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Window registers follow the next-window logic; the key is held per query.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      lo_r <= '0;
      hi_r <= count_sat;
      if (accept && (in_func == FUNC_QUERY)) begin
        key_r <= in_search_key;
      end
    end else begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt[IDX_W-1:0];
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_result_index = out_result_index_r;
  assign out_status       = out_status_r;

  // The probed index always lies strictly inside the current window.
  `STFS_ASSERT_SAME(a_mid_in_window, state_r == S_PROBE, ({1'b0, mid_r} < hi_r) && (mid_r > lo_r), "probe index outside the window")
  // A result is only given while the sequencer is idle.
  `STFS_ASSERT_SAME(a_strobe_not_busy, out_strobe, !busy, "result strobe while busy")
  // Only a found result carries a nonzero index.
  `STFS_ASSERT_SAME(a_index_zero, out_strobe && (out_status != ST_FOUND), out_result_index == '0, "nonzero index with error status")
  // A load item never produces a result.
  `STFS_ASSERT_NEXT(a_load_silent, accept && (in_func == FUNC_WRITE), !out_strobe, "result after a load item")
  // A short table answers at once with the small-count status.
  `STFS_ASSERT_NEXT(a_small_count, accept && (in_func == FUNC_QUERY) && (count_sat < COUNT_W'(2)), out_strobe && (out_status == ST_SMALL), "small count not reported")

endmodule
